### src/getb_pkg.sv
// Shared types, widths and register codes of the greedy edge tour builder.
package getb_pkg;

  localparam int IDX_W           = 10;
  localparam int CNT_W           = 11;
  localparam int COST_W          = 32;
  localparam int SUM_W           = 48;
  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_COST_BITS   = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;
  localparam logic [CNT_W-1:0] MIN_NODES      = 11'd2;

  // register index, taken from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic [IDX_W-1:0]  end_a;
    logic [IDX_W-1:0]  end_b;
    logic [COST_W-1:0] edge_cost;
  } edge_in_t;

  typedef struct packed {
    logic              accepted;
    logic [CNT_W-1:0]  edges_taken;
    logic [SUM_W-1:0]  running_cost;
    logic              path_complete;
    logic [IDX_W-1:0]  close_from;
    logic [IDX_W-1:0]  close_to;
  } result_t;

  // classified edge handed from the front to the back
  typedef struct packed {
    logic [IDX_W-1:0]  end_a;
    logic [IDX_W-1:0]  end_b;
    logic [COST_W-1:0] cost;
    logic              pre_ok;
    logic [CNT_W-1:0]  last_count;
  } work_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

### src/getb_ram.sv
// Generic RAM: one write port, two registered read ports.
module getb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

### src/getb_queue.sv
// Short FIFO of classified edges between the front and the back.
module getb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  getb_pkg::work_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output getb_pkg::work_t head_o
);

  localparam int Depth = getb_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  getb_pkg::work_t     slot_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/getb_front.sv
// Front: accept edge beats, clamp the node count, range-check and mask the cost.
module getb_front #(
  parameter int MAX_NODES = getb_pkg::DEF_MAX_NODES,
  parameter int COST_BITS = getb_pkg::DEF_COST_BITS
) (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  getb_pkg::edge_in_t           in_data_i,
  input  logic [getb_pkg::CNT_W-1:0]   node_count_i,
  input  getb_pkg::back_status_t       back_status_i,
  input  logic                         queue_full_i,
  output logic                         push_o,
  output getb_pkg::work_t              push_data_o
);

  localparam int CntW  = getb_pkg::CNT_W;
  localparam int CostW = getb_pkg::COST_W;
  localparam logic [CostW-1:0] CostMask =
    (COST_BITS >= CostW) ? '1 : CostW'((64'd1 << COST_BITS) - 64'd1);

  logic [CntW-1:0] eff_nodes;

  always_comb begin
    if (node_count_i < getb_pkg::MIN_NODES) begin
      eff_nodes = getb_pkg::MIN_NODES;
    end else if (32'(node_count_i) > MAX_NODES) begin
      eff_nodes = CntW'(MAX_NODES);
    end else begin
      eff_nodes = node_count_i;
    end
  end

  assign in_stall_o = queue_full_i || back_status_i.clearing;
  assign push_o     = in_valid_i && !in_stall_o;

  always_comb begin
    push_data_o.end_a      = in_data_i.end_a;
    push_data_o.end_b      = in_data_i.end_b;
    push_data_o.cost       = in_data_i.edge_cost & CostMask;
    push_data_o.pre_ok     = (CntW'(in_data_i.end_a) < eff_nodes) &&
                             (CntW'(in_data_i.end_b) < eff_nodes) &&
                             (in_data_i.end_a != in_data_i.end_b);
    push_data_o.last_count = CntW'(eff_nodes - 1'b1);
  end

endmodule

### src/getb_back.sv
// Back: clear the node memories, then look up, judge and commit one edge at a time.
module getb_back #(
  parameter int MAX_NODES = getb_pkg::DEF_MAX_NODES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  getb_pkg::work_t        head_i,
  output logic                   pop_o,
  output getb_pkg::back_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output getb_pkg::result_t      out_data_o
);

  localparam int IdxW  = getb_pkg::IDX_W;
  localparam int CntW  = getb_pkg::CNT_W;
  localparam int CostW = getb_pkg::COST_W;
  localparam int SumW  = getb_pkg::SUM_W;
  localparam int ExtW  = SumW + 1;
  localparam int Depth = (MAX_NODES < (1 << IdxW)) ? MAX_NODES : (1 << IdxW);
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_WR2   = 5'b01000,
    S_SEND  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0] clr_q, clr_d;

  // current edge
  logic [AddrW-1:0] a_q, b_q;
  logic [IdxW-1:0]  b_full_q;
  logic [CostW-1:0] cost_q;
  logic             pre_ok_q;
  logic [CntW-1:0]  last_q;

  // second write pass
  logic             wr2_deg_q, wr2_far_q;
  logic [1:0]       deg_b_new_q;
  logic [AddrW-1:0] fa_q, fb_q;

  // tour state
  logic [CntW-1:0]  taken_q;
  logic [SumW-1:0]  sum_q;
  logic             done_q;
  logic [IdxW-1:0]  close_from_q, close_to_q;
  logic             acc_q;

  logic              out_valid_q;
  getb_pkg::result_t out_data_q;

  // memory ports
  logic             deg_we, far_we;
  logic [AddrW-1:0] deg_waddr, far_waddr, far_wdata;
  logic [1:0]       deg_wdata;
  logic [1:0]       deg_a, deg_b;
  logic [AddrW-1:0] far_a, far_b;
  logic [AddrW-1:0] rd_a, rd_b;

  assign rd_a = head_i.end_a[AddrW-1:0];
  assign rd_b = head_i.end_b[AddrW-1:0];

  getb_ram #(.WIDTH(2), .DEPTH(Depth)) u_deg_ram (
    .clk_i    (clk_i),
    .we_i     (deg_we),
    .waddr_i  (deg_waddr),
    .wdata_i  (deg_wdata),
    .raddr0_i (rd_a),
    .raddr1_i (rd_b),
    .rdata0_o (deg_a),
    .rdata1_o (deg_b)
  );

  getb_ram #(.WIDTH(AddrW), .DEPTH(Depth)) u_far_ram (
    .clk_i    (clk_i),
    .we_i     (far_we),
    .waddr_i  (far_waddr),
    .wdata_i  (far_wdata),
    .raddr0_i (rd_a),
    .raddr1_i (rd_b),
    .rdata0_o (far_a),
    .rdata1_o (far_b)
  );

  logic            accept, complete;
  logic [CntW-1:0] taken_nx;
  logic [ExtW-1:0] sum_ext;
  logic [SumW-1:0] sum_sat;
  logic            out_free;

  assign accept   = !done_q && pre_ok_q && (deg_a < 2'd2) && (deg_b < 2'd2) &&
                    (IdxW'(far_a) != b_full_q);
  assign taken_nx = CntW'(taken_q + 1'b1);
  assign complete = (taken_nx >= last_q);
  assign sum_ext  = {1'b0, sum_q} + ExtW'(cost_q);
  assign sum_sat  = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  assign pop_o             = (state_q == S_IDLE) && !empty_i;
  assign status_o.clearing = (state_q == S_CLEAR);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = AddrW'(clr_q + 1'b1);
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL:  state_d = S_WR2;
      S_WR2:   state_d = out_free ? S_IDLE : S_SEND;
      S_SEND:  state_d = out_free ? S_IDLE : S_SEND;
      default: state_d = S_CLEAR;
    endcase
  end

  // write port steering: clearing pass, first pair in EVAL, second pair in WR2
  always_comb begin
    deg_we    = 1'b0;
    deg_waddr = a_q;
    deg_wdata = 2'(deg_a + 2'd1);
    far_we    = 1'b0;
    far_waddr = far_a;
    far_wdata = far_b;
    case (state_q)
      S_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = clr_q;
        deg_wdata = 2'd0;
        far_we    = 1'b1;
        far_waddr = clr_q;
        far_wdata = clr_q;
      end
      S_EVAL: begin
        deg_we = accept;
        far_we = accept && !complete;
      end
      S_WR2: begin
        deg_we    = wr2_deg_q;
        deg_waddr = b_q;
        deg_wdata = deg_b_new_q;
        far_we    = wr2_far_q;
        far_waddr = fb_q;
        far_wdata = fa_q;
      end
      default: begin
        deg_we = 1'b0;
        far_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      taken_q      <= '0;
      sum_q        <= '0;
      done_q       <= 1'b0;
      close_from_q <= '0;
      close_to_q   <= '0;
      wr2_deg_q    <= 1'b0;
      wr2_far_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (state_q == S_EVAL) begin
        wr2_deg_q <= accept;
        wr2_far_q <= accept && !complete;
        if (accept) begin
          taken_q <= taken_nx;
          sum_q   <= sum_sat;
          if (complete) begin
            done_q <= 1'b1;
            if (far_a < far_b) begin
              close_from_q <= IdxW'(far_a);
              close_to_q   <= IdxW'(far_b);
            end else begin
              close_from_q <= IdxW'(far_b);
              close_to_q   <= IdxW'(far_a);
            end
          end
        end
      end
      // drop the beat once taken, load a fresh one when the edge is finished
      if ((state_q == S_WR2 || state_q == S_SEND) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_q      <= rd_a;
      b_q      <= rd_b;
      b_full_q <= head_i.end_b;
      cost_q   <= head_i.cost;
      pre_ok_q <= head_i.pre_ok;
      last_q   <= head_i.last_count;
    end
    if (state_q == S_EVAL) begin
      acc_q       <= accept;
      deg_b_new_q <= 2'(deg_b + 2'd1);
      fa_q        <= far_a;
      fb_q        <= far_b;
    end
    if ((state_q == S_WR2 || state_q == S_SEND) && out_free) begin
      out_data_q.accepted      <= acc_q;
      out_data_q.edges_taken   <= taken_q;
      out_data_q.running_cost  <= sum_q;
      out_data_q.path_complete <= done_q;
      out_data_q.close_from    <= close_from_q;
      out_data_q.close_to      <= close_to_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### src/greedy_edge_tour_builder.sv
// Greedy edge tour builder: one result beat per offered edge, in order.
// The back takes one edge at a time through read, evaluate and second write pass
//   on the single-write-port degree and far-end memories; a 2-deep queue decouples input.
// Reset: control clears at once, then a clearing pass over min(MAX_NODES, 1024) entries
//   rewrites the node memories; in_stall_o stays high during it, APB writes still land.
module greedy_edge_tour_builder #(
  parameter int MAX_NODES = getb_pkg::DEF_MAX_NODES,
  parameter int COST_BITS = getb_pkg::DEF_COST_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  getb_pkg::edge_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output getb_pkg::result_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [getb_pkg::PADDR_W-1:0]  paddr,
  input  logic [getb_pkg::PDATA_W-1:0]  pwdata,
  output logic [getb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int CntW   = getb_pkg::CNT_W;
  localparam int PdataW = getb_pkg::PDATA_W;

  logic [CntW-1:0] node_count_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == getb_pkg::REG_NODE_COUNT);
  assign prdata = (paddr[2] == getb_pkg::REG_NODE_COUNT) ? PdataW'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= getb_pkg::NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count_q <= pwdata[CntW-1:0];
    end
  end

  getb_pkg::back_status_t back_status;
  getb_pkg::work_t        push_data, head;
  logic                   push, pop, full, empty;

  getb_front #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .node_count_i  (node_count_q),
    .back_status_i (back_status),
    .queue_full_i  (full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  getb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  getb_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .status_o    (back_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
